// ===== design/stc_pkg.sv =====
`default_nettype none
package stc_pkg;

  // request codes
  localparam logic [1:0] REQ_OBSERVE = 2'd0;
  localparam logic [1:0] REQ_QUERY   = 2'd1;
  localparam logic [1:0] REQ_RESOLVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  // status codes
  localparam logic [3:0] ST_NEW      = 4'd0;
  localparam logic [3:0] ST_UPDATED  = 4'd1;
  localparam logic [3:0] ST_DISABLED = 4'd2;
  localparam logic [3:0] ST_NOKEY    = 4'd3;
  localparam logic [3:0] ST_LOWCONF  = 4'd4;
  localparam logic [3:0] ST_QHIT     = 4'd5;
  localparam logic [3:0] ST_QMISS    = 4'd6;
  localparam logic [3:0] ST_RESOLVED = 4'd7;
  localparam logic [3:0] ST_RMISS    = 4'd8;
  localparam logic [3:0] ST_FEWHITS  = 4'd9;
  localparam logic [3:0] ST_LOWINPUT = 4'd10;
  localparam logic [3:0] ST_CLEARED  = 4'd11;

  // config register indexes
  localparam logic [2:0] CFG_ENABLED    = 3'd0;
  localparam logic [2:0] CFG_TOP_K      = 3'd1;
  localparam logic [2:0] CFG_MIN_CONF   = 3'd2;
  localparam logic [2:0] CFG_OUT_CAP    = 3'd3;
  localparam logic [2:0] CFG_MIN_HITS   = 3'd4;
  localparam logic [2:0] CFG_MIN_ENERGY = 3'd5;

  localparam logic [15:0] LOW_LEVEL = 16'd3277;
  localparam logic [7:0]  TTL_MIN   = 8'd24;
  localparam logic [7:0]  TTL_MAX   = 8'd180;
  localparam logic [10:0] BONUS_MUL = 11'd1363;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOKUP, S_SCAN, S_LOG, S_BONUS, S_CMP, S_EXEC, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] form_id;
    logic [7:0]  event_type;
    logic [15:0] left_level;
    logic [15:0] right_level;
    logic [15:0] confidence;
    logic [15:0] match_score;
    logic [7:0]  priority_req;
    logic [15:0] ttl_ms;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        evicted;
    logic [31:0] out_form_id;
    logic [7:0]  out_event_type;
    logic [15:0] out_left;
    logic [15:0] out_right;
    logic [15:0] out_confidence;
    logic [7:0]  out_priority;
    logic [7:0]  out_ttl_ms;
  } out_word_t;

  function automatic logic [15:0] avg4(input logic [15:0] old, input logic [15:0] s);
    logic [18:0] t;
    t = 19'({old, 1'b0}) + 19'(old) + 19'(s) + 19'd2;
    return t[17:2];
  endfunction

  function automatic logic [7:0] clamp_ttl(input logic [15:0] t);
    if (t < 16'(TTL_MIN)) return TTL_MIN;
    if (t > 16'(TTL_MAX)) return TTL_MAX;
    return t[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/stc_if.sv =====
`default_nettype none
interface stc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/scored_template_cache_unit.sv =====
// Scored template cache.
// in  : request words (observe, query, resolve, clear) on a valid/ready channel.
// out : one result word per request on a valid/ready channel, held in an
//       output register until taken.
// cfg : write enable, index and 16-bit data; write only while idle.
// Key match is registered in the lookup state. An observe that inserts while
// the table holds the top-k limit of entries scans every slot through one
// shared log2 unit and one compare: each valid slot passes through scan,
// log2 by repeated squaring, bonus and compare; an empty slot is skipped.
// All other requests pass through lookup, scan, exec and done before their
// result word is valid. One request is in flight at a time; in_ready is low
// meanwhile, until the block is idle again with its output register empty.
// If the output is stalled the finished word waits in the output register
// and the next request is not taken until it leaves.
// Reset empties the table (valid bits cleared) and loads register defaults.
// Slot payload is unset until written and is only read for valid slots.
`default_nettype none
module scored_template_cache_unit #(
  parameter int ENTRIES   = 16,
  parameter int HIT_LIMIT = 1023
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  stc_if.sink              in_ch,
  stc_if.source            out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int HW = $clog2(HIT_LIMIT + 1);
  localparam logic [HW-1:0] HLIM = HW'(HIT_LIMIT);

  // config
  logic        enabled_r;
  logic [4:0]  top_k_r;
  logic [15:0] min_conf_r, out_cap_r, min_energy_r;
  logic [9:0]  min_hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1; top_k_r <= 5'd16; min_conf_r <= 16'd32768;
      out_cap_r <= 16'hFFFF; min_hits_r <= 10'd1; min_energy_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stc_pkg::CFG_ENABLED:    enabled_r    <= cfg_data[0];
        stc_pkg::CFG_TOP_K:      top_k_r      <= cfg_data[4:0];
        stc_pkg::CFG_MIN_CONF:   min_conf_r   <= cfg_data;
        stc_pkg::CFG_OUT_CAP:    out_cap_r    <= cfg_data;
        stc_pkg::CFG_MIN_HITS:   min_hits_r   <= cfg_data[9:0];
        stc_pkg::CFG_MIN_ENERGY: min_energy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot storage
  logic [ENTRIES-1:0] valid_r;
  logic [31:0]  s_form  [ENTRIES];
  logic [7:0]   s_ev    [ENTRIES];
  logic [15:0]  s_left  [ENTRIES];
  logic [15:0]  s_right [ENTRIES];
  logic [15:0]  s_conf  [ENTRIES];
  logic [7:0]   s_prio  [ENTRIES];
  logic [7:0]   s_ttl   [ENTRIES];
  logic [15:0]  s_score [ENTRIES];
  logic [HW-1:0] s_hits [ENTRIES];
  logic [CW-1:0] used_r;

  stc_pkg::state_t state_r, state_nxt;
  stc_pkg::in_word_t req_r;
  stc_pkg::out_word_t res_r;
  logic out_valid_r;

  logic          hit_r;
  logic [IW-1:0] hidx_r;
  logic [IW-1:0] scan_r;        // slot under scan
  logic          have_worst_r;
  logic [IW-1:0] worst_r;
  logic [16:0]   worst_rank_r;
  logic          evicted_r;
  // shared log2 unit
  logic [31:0]   y_r;
  logic [4:0]    lstep_r;
  logic [4:0]    ln_r;
  logic [15:0]   frac_r;
  logic [16:0]   rank_r;

  // derived request values
  logic [15:0] c_val, lr_max;
  logic        no_key;
  assign c_val  = (req_r.match_score > req_r.confidence) ? req_r.match_score
                                                         : req_r.confidence;
  assign lr_max = (req_r.left_level > req_r.right_level) ? req_r.left_level
                                                         : req_r.right_level;
  assign no_key = (req_r.form_id == 32'd0) && (req_r.event_type == 8'd0);

  // parallel key match
  logic [ENTRIES-1:0] match_v;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (req_r.form_id != 32'd0)
        match_v[i] = valid_r[i] && (s_form[i] == req_r.form_id);
      else
        match_v[i] = valid_r[i] && (s_form[i] == 32'd0) && (s_ev[i] == req_r.event_type);
    end
  end
  logic          m_any;
  logic [IW-1:0] m_idx;
  always_comb begin
    m_any = 1'b0; m_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (match_v[i]) begin m_any = 1'b1; m_idx = IW'(i); end
  end

  // lowest free slot
  logic          f_any;
  logic [IW-1:0] f_idx;
  always_comb begin
    f_any = 1'b0; f_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (!valid_r[i]) begin f_any = 1'b1; f_idx = IW'(i); end
  end

  // capacity limit
  logic [CW-1:0] lim;
  always_comb begin
    logic [5:0] k;
    k = (top_k_r == 5'd0) ? 6'd1 : 6'(top_k_r);
    lim = (32'(k) > ENTRIES) ? CW'(ENTRIES) : CW'(k);
  end

  logic is_observe_miss;
  assign is_observe_miss = (req_r.req_type == stc_pkg::REQ_OBSERVE) && enabled_r && !no_key
    && !(c_val < min_conf_r || lr_max < stc_pkg::LOW_LEVEL) && !hit_r;
  logic need_evict;
  assign need_evict = is_observe_miss && (used_r >= lim) && (valid_r != '0);

  // log2 of (hits+1) setup
  logic [16:0] x_val;
  logic [4:0]  x_n;
  assign x_val = 17'(s_hits[scan_r]) + 17'd1;
  always_comb begin
    x_n = '0;
    for (int i = 1; i < 17; i++) if (x_val[i]) x_n = 5'(i);
  end
  // one squaring step
  logic [63:0] sq;
  logic [31:0] y_sq;
  assign sq   = 64'(y_r) * 64'(y_r);
  assign y_sq = sq[61:30];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stc_pkg::S_IDLE:   if (in_ch.valid && !out_valid_r) state_nxt = stc_pkg::S_LOOKUP;
      stc_pkg::S_LOOKUP: state_nxt = stc_pkg::S_SCAN;
      stc_pkg::S_SCAN: begin
        if (!need_evict) state_nxt = stc_pkg::S_EXEC;
        else if (valid_r[scan_r]) state_nxt = stc_pkg::S_LOG;
        else if (32'(scan_r) == ENTRIES - 1) state_nxt = stc_pkg::S_EXEC;
      end
      stc_pkg::S_LOG:   if (lstep_r == 5'd0) state_nxt = stc_pkg::S_BONUS;
      stc_pkg::S_BONUS: state_nxt = stc_pkg::S_CMP;
      stc_pkg::S_CMP:   state_nxt = (32'(scan_r) == ENTRIES - 1) ? stc_pkg::S_EXEC
                                                                 : stc_pkg::S_SCAN;
      stc_pkg::S_EXEC:  state_nxt = stc_pkg::S_DONE;
      stc_pkg::S_DONE:  state_nxt = stc_pkg::S_IDLE;
      default:          state_nxt = stc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= stc_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // outputs
  assign in_ch.ready  = (state_r == stc_pkg::S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      used_r      <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        stc_pkg::S_IDLE: if (in_ch.valid && !out_valid_r) req_r <= in_ch.data;
        stc_pkg::S_LOOKUP: begin
          hit_r <= m_any; hidx_r <= m_idx;
          scan_r <= '0; have_worst_r <= 1'b0; evicted_r <= 1'b0;
        end
        stc_pkg::S_SCAN: if (need_evict) begin
          if (valid_r[scan_r]) begin
            ln_r    <= x_n;
            y_r     <= 32'((48'(x_val) << 30) >> x_n);
            lstep_r <= 5'd16;
            frac_r  <= '0;
          end else begin
            scan_r <= scan_r + IW'(1);
          end
        end
        stc_pkg::S_LOG: if (lstep_r != 5'd0) begin
          lstep_r <= lstep_r - 5'd1;
          if (y_sq[31]) begin
            y_r <= {1'b0, y_sq[31:1]};
            frac_r[4'(lstep_r - 5'd1)] <= 1'b1;
          end else y_r <= y_sq;
        end
        stc_pkg::S_BONUS: begin
          logic [31:0] p;
          p = 32'({ln_r, frac_r}) * 32'(stc_pkg::BONUS_MUL) + 32'd32768;
          rank_r <= 17'(s_score[scan_r]) + 17'(p[31:16]);
        end
        stc_pkg::S_CMP: begin
          if (!have_worst_r || rank_r < worst_rank_r) begin
            have_worst_r <= 1'b1; worst_r <= scan_r; worst_rank_r <= rank_r;
          end
          if (32'(scan_r) != ENTRIES - 1) scan_r <= scan_r + IW'(1);
        end
        stc_pkg::S_EXEC: begin
          if (need_evict && have_worst_r) begin
            valid_r[worst_r] <= 1'b0;
            used_r    <= used_r - CW'(1);
            evicted_r <= 1'b1;
          end
        end
        stc_pkg::S_DONE: begin
          stc_pkg::out_word_t r;
          r = '0;
          out_valid_r <= 1'b1;
          if (req_r.req_type == stc_pkg::REQ_CLEAR) begin
            valid_r <= '0; used_r <= '0; r.status = stc_pkg::ST_CLEARED;
          end else if (!enabled_r) r.status = stc_pkg::ST_DISABLED;
          else if (no_key) r.status = stc_pkg::ST_NOKEY;
          else begin
            case (req_r.req_type)
              stc_pkg::REQ_OBSERVE: begin
                if (c_val < min_conf_r || lr_max < stc_pkg::LOW_LEVEL)
                  r.status = stc_pkg::ST_LOWCONF;
                else if (!hit_r) begin
                  r.status = stc_pkg::ST_NEW; r.evicted = evicted_r;
                  if (f_any) begin
                    valid_r[f_idx] <= 1'b1;
                    s_form[f_idx] <= req_r.form_id; s_ev[f_idx] <= req_r.event_type;
                    s_left[f_idx] <= req_r.left_level; s_right[f_idx] <= req_r.right_level;
                    s_conf[f_idx] <= c_val; s_score[f_idx] <= c_val;
                    s_prio[f_idx] <= req_r.priority_req;
                    s_ttl[f_idx] <= stc_pkg::clamp_ttl(req_r.ttl_ms);
                    s_hits[f_idx] <= HW'(1);
                    used_r <= used_r + CW'(1);
                  end
                end else begin
                  r.status = stc_pkg::ST_UPDATED;
                  if (req_r.form_id != 32'd0) s_form[hidx_r] <= req_r.form_id;
                  if (req_r.event_type != 8'd0) s_ev[hidx_r] <= req_r.event_type;
                  s_left[hidx_r]  <= stc_pkg::avg4(s_left[hidx_r], req_r.left_level);
                  s_right[hidx_r] <= stc_pkg::avg4(s_right[hidx_r], req_r.right_level);
                  s_conf[hidx_r]  <= stc_pkg::avg4(s_conf[hidx_r], c_val);
                  s_score[hidx_r] <= stc_pkg::avg4(s_score[hidx_r], c_val);
                  if (req_r.priority_req > s_prio[hidx_r]) s_prio[hidx_r] <= req_r.priority_req;
                  s_ttl[hidx_r] <= stc_pkg::clamp_ttl(req_r.ttl_ms);
                  if (s_hits[hidx_r] < HLIM) s_hits[hidx_r] <= s_hits[hidx_r] + HW'(1);
                end
              end
              stc_pkg::REQ_QUERY:
                r.status = hit_r ? stc_pkg::ST_QHIT : stc_pkg::ST_QMISS;
              default: begin
                if (!hit_r) r.status = stc_pkg::ST_RMISS;
                else if (32'(s_hits[hidx_r]) <
                         ((min_hits_r == 10'd0) ? 32'd1 : 32'(min_hits_r)))
                  r.status = stc_pkg::ST_FEWHITS;
                else if (lr_max < min_energy_r) r.status = stc_pkg::ST_LOWINPUT;
                else begin
                  logic [15:0] cc;
                  if (s_hits[hidx_r] < HLIM) s_hits[hidx_r] <= s_hits[hidx_r] + HW'(1);
                  r.status = stc_pkg::ST_RESOLVED;
                  r.out_form_id = (req_r.form_id != 32'd0) ? req_r.form_id : s_form[hidx_r];
                  r.out_event_type = (req_r.event_type != 8'd0) ? req_r.event_type
                                                                : s_ev[hidx_r];
                  r.out_left  = (s_left[hidx_r] < out_cap_r) ? s_left[hidx_r] : out_cap_r;
                  r.out_right = (s_right[hidx_r] < out_cap_r) ? s_right[hidx_r] : out_cap_r;
                  cc = (s_conf[hidx_r] < out_cap_r) ? s_conf[hidx_r] : out_cap_r;
                  r.out_confidence = (req_r.confidence > cc) ? req_r.confidence : cc;
                  r.out_priority = (req_r.priority_req > s_prio[hidx_r]) ? req_r.priority_req
                                                                         : s_prio[hidx_r];
                  r.out_ttl_ms = stc_pkg::clamp_ttl(16'(s_ttl[hidx_r]));
                end
              end
            endcase
          end
          res_r <= r;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sim/scored_template_cache_unit_tb.sv =====
`default_nettype none
module scored_template_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int HITS_MAX = 1023;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit          valid;
    logic [31:0] form_id;
    logic [7:0]  ev;
    logic [15:0] left, right, conf, score;
    logic [7:0]  prio, ttl;
    int unsigned hits;
  } slot_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  stc_if #(.T(stc_pkg::in_word_t))  in_ch ();
  stc_if #(.T(stc_pkg::out_word_t)) out_ch ();

  scored_template_cache_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the template table and registers
  slot_t       cache [NSLOT];
  int unsigned used_cnt;
  bit          m_enabled;
  logic [4:0]  m_top_k;
  logic [15:0] m_min_conf, m_cap, m_min_energy;
  logic [9:0]  m_min_hits;

  stc_pkg::out_word_t expected_words[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int out_stall = 0;
  bit idle_in;
  bit idle_out = 1'b1;
  logic [31:0] form_pool [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // log2 in Q16.16 by repeated squaring, fraction truncated
  function automatic longint unsigned log2_q16(int unsigned x);
    int unsigned n;
    longint unsigned y, frac;
    n = 0;
    frac = 0;
    if (x == 0) return 0;
    while (n < 31 && (x >> n) > 1) n++;
    y = (longint'(x) << 30) >> n;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac |= 64'd1 << i;
      end
    end
    return (longint'(n) << 16) | frac;
  endfunction

  function automatic longint unsigned rank(int s);
    return longint'(cache[s].score) +
           ((log2_q16(cache[s].hits + 1) * stc_pkg::BONUS_MUL + 32768) >> 16);
  endfunction

  function automatic logic [15:0] mavg(logic [15:0] o, logic [15:0] s);
    int unsigned t;
    t = (3 * o + s + 2) >> 2;
    return t[15:0];
  endfunction

  function automatic logic [7:0] ttl_clamp(logic [15:0] t);
    return t < 24 ? 8'd24 : (t > 180 ? 8'd180 : t[7:0]);
  endfunction

  function automatic int unsigned hit_inc(int unsigned h);
    return h >= HITS_MAX ? HITS_MAX : h + 1;
  endfunction

  function automatic logic [15:0] max16(logic [15:0] a, logic [15:0] b);
    return a > b ? a : b;
  endfunction

  function automatic logic [15:0] min16(logic [15:0] a, logic [15:0] b);
    return a < b ? a : b;
  endfunction

  // expected result of one request; updates the shadow table
  function automatic stc_pkg::out_word_t cache_predict(stc_pkg::in_word_t w);
    stc_pkg::out_word_t r;
    int idx, worst, lim, fr;
    logic [15:0] c;
    longint unsigned wr;
    r = '0;
    if (w.req_type == stc_pkg::REQ_CLEAR) begin
      foreach (cache[i]) cache[i].valid = 0;
      used_cnt = 0;
      r.status = stc_pkg::ST_CLEARED;
      return r;
    end
    if (!m_enabled) begin
      r.status = stc_pkg::ST_DISABLED;
      return r;
    end
    if (w.form_id == 0 && w.event_type == 0) begin
      r.status = stc_pkg::ST_NOKEY;
      return r;
    end
    idx = -1;
    for (int i = 0; i < NSLOT && idx < 0; i++)
      if (cache[i].valid) begin
        if (w.form_id != 0) begin
          if (cache[i].form_id == w.form_id) idx = i;
        end else if (cache[i].form_id == 0 && cache[i].ev == w.event_type) begin
          idx = i;
        end
      end
    case (w.req_type)
      stc_pkg::REQ_OBSERVE: begin
        c = max16(w.match_score, w.confidence);
        if (c < m_min_conf ||
            max16(w.left_level, w.right_level) < stc_pkg::LOW_LEVEL) begin
          r.status = stc_pkg::ST_LOWCONF;
        end else if (idx < 0) begin
          lim = (m_top_k == 0) ? 1 : m_top_k;
          if (lim > NSLOT) lim = NSLOT;
          if (used_cnt >= lim) begin
            worst = -1;
            wr = 0;
            for (int i = 0; i < NSLOT; i++)
              if (cache[i].valid && (worst < 0 || rank(i) < wr)) begin
                worst = i;
                wr = rank(i);
              end
            if (worst >= 0) begin
              cache[worst].valid = 0;
              if (used_cnt > 0) used_cnt--;
              r.evicted = 1'b1;
            end
          end
          fr = -1;
          for (int i = 0; i < NSLOT && fr < 0; i++)
            if (!cache[i].valid) fr = i;
          r.status = stc_pkg::ST_NEW;
          if (fr >= 0) begin
            cache[fr].valid = 1;
            cache[fr].form_id = w.form_id;
            cache[fr].ev = w.event_type;
            cache[fr].left = w.left_level;
            cache[fr].right = w.right_level;
            cache[fr].conf = c;
            cache[fr].score = c;
            cache[fr].prio = w.priority_req;
            cache[fr].ttl = ttl_clamp(w.ttl_ms);
            cache[fr].hits = 1;
            used_cnt++;
          end
        end else begin
          if (w.form_id != 0) cache[idx].form_id = w.form_id;
          if (w.event_type != 0) cache[idx].ev = w.event_type;
          cache[idx].left = mavg(cache[idx].left, w.left_level);
          cache[idx].right = mavg(cache[idx].right, w.right_level);
          cache[idx].conf = mavg(cache[idx].conf, c);
          cache[idx].score = mavg(cache[idx].score, c);
          if (w.priority_req > cache[idx].prio) cache[idx].prio = w.priority_req;
          cache[idx].ttl = ttl_clamp(w.ttl_ms);
          cache[idx].hits = hit_inc(cache[idx].hits);
          r.status = stc_pkg::ST_UPDATED;
        end
      end
      stc_pkg::REQ_QUERY: r.status = (idx >= 0) ? stc_pkg::ST_QHIT : stc_pkg::ST_QMISS;
      default: begin
        if (idx < 0) begin
          r.status = stc_pkg::ST_RMISS;
        end else if (cache[idx].hits < ((m_min_hits == 0) ? 1 : m_min_hits)) begin
          r.status = stc_pkg::ST_FEWHITS;
        end else if (max16(w.left_level, w.right_level) < m_min_energy) begin
          r.status = stc_pkg::ST_LOWINPUT;
        end else begin
          cache[idx].hits = hit_inc(cache[idx].hits);
          r.status = stc_pkg::ST_RESOLVED;
          r.out_form_id = (w.form_id != 0) ? w.form_id : cache[idx].form_id;
          r.out_event_type = (w.event_type != 0) ? w.event_type : cache[idx].ev;
          r.out_left = min16(cache[idx].left, m_cap);
          r.out_right = min16(cache[idx].right, m_cap);
          r.out_confidence = max16(w.confidence, min16(cache[idx].conf, m_cap));
          r.out_priority = (w.priority_req > cache[idx].prio) ?
                           w.priority_req : cache[idx].prio;
          r.out_ttl_ms = ttl_clamp({8'd0, cache[idx].ttl});
        end
      end
    endcase
    return r;
  endfunction

  function automatic int gap_len(bit on);
    if (!on) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one word; valid stays high when the next word follows at once
  task automatic send_word(stc_pkg::in_word_t w);
    int g;
    g = gap_len(idle_in);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    expected_words.push_back(cache_predict(w));
    if ($urandom_range(0, 49) == 0) idle_in = ~idle_in;
  endtask

  // wait until every expected word has arrived and the block is idle
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      stc_pkg::CFG_ENABLED:    m_enabled = val[0];
      stc_pkg::CFG_TOP_K:      m_top_k = val[4:0];
      stc_pkg::CFG_MIN_CONF:   m_min_conf = val;
      stc_pkg::CFG_OUT_CAP:    m_cap = val;
      stc_pkg::CFG_MIN_HITS:   m_min_hits = val[9:0];
      stc_pkg::CFG_MIN_ENERGY: m_min_energy = val;
      default: ;
    endcase
  endtask

  task automatic set_config(bit en, logic [4:0] k, logic [15:0] mc, logic [15:0] cap,
                            logic [9:0] mh, logic [15:0] me);
    drain();
    cfg_write(stc_pkg::CFG_ENABLED, {15'd0, en});
    cfg_write(stc_pkg::CFG_TOP_K, {11'd0, k});
    cfg_write(stc_pkg::CFG_MIN_CONF, mc);
    cfg_write(stc_pkg::CFG_OUT_CAP, cap);
    cfg_write(stc_pkg::CFG_MIN_HITS, {6'd0, mh});
    cfg_write(stc_pkg::CFG_MIN_ENERGY, me);
  endtask

  function automatic stc_pkg::in_word_t mk(logic [1:0] rq, logic [31:0] f, logic [7:0] e,
                                           logic [15:0] l, logic [15:0] r,
                                           logic [15:0] c);
    stc_pkg::in_word_t w;
    w.req_type = rq;
    w.form_id = f;
    w.event_type = e;
    w.left_level = l;
    w.right_level = r;
    w.confidence = c;
    w.match_score = 16'(c >> 1);
    w.priority_req = 8'($urandom);
    w.ttl_ms = 16'($urandom);
    return w;
  endfunction

  // mostly keys from a small pool so that entries get hit and evicted
  function automatic stc_pkg::in_word_t rand_word();
    stc_pkg::in_word_t w;
    int p;
    w = '0;
    p = $urandom_range(0, 99);
    w.req_type = p < 50 ? stc_pkg::REQ_OBSERVE : p < 65 ? stc_pkg::REQ_QUERY :
                 p < 98 ? stc_pkg::REQ_RESOLVE : stc_pkg::REQ_CLEAR;
    p = $urandom_range(0, 19);
    if (p < 12) begin
      w.form_id = form_pool[$urandom_range(0, 7)];
    end else if (p < 14) begin
      w.form_id = $urandom;
    end
    w.event_type = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    if ($urandom_range(0, 9) == 0) w.left_level = 16'($urandom_range(0, 4000));
    else w.left_level = 16'($urandom);
    w.right_level = 16'($urandom);
    w.confidence = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                   16'($urandom_range(40000, 65535));
    w.match_score = 16'($urandom);
    w.priority_req = 8'($urandom);
    w.ttl_ms = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 250));
    return w;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_word(rand_word());
  endtask

  // directed corners with reset settings
  task automatic test_directed;
    send_word(mk(stc_pkg::REQ_OBSERVE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(mk(stc_pkg::REQ_OBSERVE, 32'd0, 8'd1, 16'd3277, 16'd0, 16'd32768));
    send_word(mk(stc_pkg::REQ_OBSERVE, 32'd0, 8'd2, 16'd3276, 16'd3276, 16'hFFFF));
    send_word(mk(stc_pkg::REQ_OBSERVE, 32'd7, 8'd0, 16'hFFFF, 16'd0, 16'd32767));
    send_word(mk(stc_pkg::REQ_OBSERVE, 32'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(mk(stc_pkg::REQ_OBSERVE, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd40000, 16'd50000));
    send_word(mk(stc_pkg::REQ_OBSERVE, 32'd0, 8'd1, 16'd9000, 16'd0, 16'd60000));
    send_word(mk(stc_pkg::REQ_QUERY, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0, 16'd0));
    send_word(mk(stc_pkg::REQ_QUERY, 32'd0, 8'd1, 16'd0, 16'd0, 16'd0));
    send_word(mk(stc_pkg::REQ_QUERY, 32'd0, 8'd2, 16'd0, 16'd0, 16'd0));
    send_word(mk(stc_pkg::REQ_QUERY, 32'd0, 8'd0, 16'd0, 16'd0, 16'd0));
    send_word(mk(stc_pkg::REQ_RESOLVE, 32'd0, 8'd1, 16'd0, 16'd0, 16'd0));
    send_word(mk(stc_pkg::REQ_RESOLVE, 32'hFFFF_FFFF, 8'd9, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(mk(stc_pkg::REQ_RESOLVE, 32'd12345, 8'd0, 16'd0, 16'd0, 16'd0));
    send_word(mk(stc_pkg::REQ_RESOLVE, 32'd0, 8'd0, 16'd0, 16'd0, 16'd0));
    send_word(mk(stc_pkg::REQ_CLEAR, 32'd0, 8'd0, 16'd0, 16'd0, 16'd0));
    send_word(mk(stc_pkg::REQ_QUERY, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0, 16'd0));
  endtask

  // thresholds at the extremes, cap at zero, disabled block
  task automatic test_thresholds;
    set_config(1'b1, 5'd16, 16'd0, 16'd0, 10'd0, 16'hFFFF);
    run_random(40);
    set_config(1'b1, 5'd16, 16'hFFFF, 16'd30000, 10'd4, 16'd20000);
    run_random(40);
    set_config(1'b0, 5'd16, 16'd0, 16'hFFFF, 10'd1, 16'd0);
    run_random(15);
    send_word(mk(stc_pkg::REQ_CLEAR, 32'd0, 8'd0, 16'd0, 16'd0, 16'd0));
  endtask

  // eviction with tiny, zero and oversized limits
  task automatic test_eviction;
    set_config(1'b1, 5'd1, 16'd0, 16'hFFFF, 10'd1, 16'd0);
    run_random(40);
    set_config(1'b1, 5'd0, 16'd1000, 16'hFFFF, 10'd1, 16'd0);
    run_random(30);
    set_config(1'b1, 5'd31, 16'd1000, 16'hFFFF, 10'd1, 16'd0);
    for (int i = 0; i < 20; i++)
      send_word(mk(stc_pkg::REQ_OBSERVE, 32'h100 + i, 8'($urandom), 16'hFFFF, 16'd0,
                   16'($urandom_range(1000, 65535))));
    run_random(60);
    set_config(1'b1, 5'd5, 16'd20000, 16'd50000, 10'd3, 16'd1000);
    run_random(60);
  endtask

  // long run with reset-like settings
  task automatic test_random_mix;
    set_config(1'b1, 5'd16, 16'd32768, 16'hFFFF, 10'd1023, 16'd0);
    run_random(20);
    set_config(1'b1, 5'd16, 16'd32768, 16'hFFFF, 10'd2, 16'd0);
    run_random(100);
  endtask

  // result side: random stalls and in-order checks
  always @(posedge clk) begin
    stc_pkg::out_word_t exp_w, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        exp_w = expected_words.pop_front();
        if (got.status !== exp_w.status || got.evicted !== exp_w.evicted ||
            got.out_form_id !== exp_w.out_form_id ||
            got.out_event_type !== exp_w.out_event_type ||
            got.out_left !== exp_w.out_left || got.out_right !== exp_w.out_right ||
            got.out_confidence !== exp_w.out_confidence ||
            got.out_priority !== exp_w.out_priority ||
            got.out_ttl_ms !== exp_w.out_ttl_ms) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch expected: st=%0d ev=%0d f=%h e=%h l=%h r=%h c=%h p=%h t=%0d",
                     exp_w.status, exp_w.evicted, exp_w.out_form_id, exp_w.out_event_type,
                     exp_w.out_left, exp_w.out_right, exp_w.out_confidence,
                     exp_w.out_priority, exp_w.out_ttl_ms);
            $display("         actual:   st=%0d ev=%0d f=%h e=%h l=%h r=%h c=%h p=%h t=%0d",
                     got.status, got.evicted, got.out_form_id, got.out_event_type,
                     got.out_left, got.out_right, got.out_confidence,
                     got.out_priority, got.out_ttl_ms);
          end
        end
      end
    end
    if ($urandom_range(0, 59) == 0) idle_out <= ~idle_out;
    // ready pattern: always on, short random gaps, or an occasional long stall
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (!idle_out) begin
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_stall <= $urandom_range(10, 40);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 9) < 6);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    idle_in = 1'b1;
    used_cnt = 0;
    foreach (cache[i]) cache[i] = '{default: '0};
    m_enabled = 1'b1;
    m_top_k = 5'd16;
    m_min_conf = 16'd32768;
    m_cap = 16'hFFFF;
    m_min_hits = 10'd1;
    m_min_energy = 16'd0;
    form_pool = '{32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'd77};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_thresholds();
    test_eviction();
    test_random_mix();

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
